// ----- src/asri_pkg.sv -----
// Shared types and constants of the ADC serial register interface.
`timescale 1ns / 1ps
package asri_pkg;

	// Event codes carried on the input channel
	localparam logic [1:0] CMD_XFER   = 2'd0;
	localparam logic [1:0] CMD_CONV   = 2'd1;
	localparam logic [1:0] CMD_DESEL  = 2'd2;

	// Register select field of the communications byte
	localparam logic [2:0] REG_STATUS = 3'd0;
	localparam logic [2:0] REG_MODE   = 3'd1;
	localparam logic [2:0] REG_CONFIG = 3'd2;
	localparam logic [2:0] REG_DATA   = 3'd3;
	localparam logic [2:0] REG_ID     = 3'd4;
	localparam logic [2:0] REG_IO     = 3'd5;
	localparam logic [2:0] REG_OFFSET = 3'd6;
	localparam logic [2:0] REG_FSCALE = 3'd7;

	// Configuration port register indexes
	localparam logic CFG_CHIP_ID   = 1'b0;
	localparam logic CFG_WIDE_DATA = 1'b1;

	localparam logic [7:0]  CHIP_ID_RST   = 8'h0F;
	localparam logic        WIDE_DATA_RST = 1'b1;
	localparam logic [7:0]  ONES_BYTE     = 8'hFF;
	localparam logic [7:0]  IDLE_MISO     = 8'hFF;
	localparam logic [15:0] MODE_RST      = 16'h000A;
	localparam logic [15:0] CONFIG_RST    = 16'h0710;
	localparam logic [23:0] OFFSET_RST    = 24'h800000;
	localparam logic [23:0] FSCALE_RST    = 24'h500000;
	localparam logic [2:0]  ONES_RESET_RUN = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  mosi_byte;
		logic [23:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [7:0] miso_byte;
		logic       not_ready;
	} out_item_t;

	typedef struct packed {
		logic [7:0] chip_id;
		logic       wide_data;
	} cfg_t;

endpackage

// ----- src/asri_apb.sv -----
// APB configuration registers of the ADC serial register interface.
`timescale 1ns / 1ps
module asri_apb import asri_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [7:0] chip_id_q;
	logic       wide_data_q;
	logic       wr_en;
	logic       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_id_q   <= CHIP_ID_RST;
			wide_data_q <= WIDE_DATA_RST;
		end else if (wr_en) begin
			case (reg_idx)
				CFG_CHIP_ID:   chip_id_q   <= pwdata[7:0];
				CFG_WIDE_DATA: wide_data_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Low address bits are ignored; unused address bits are not decoded
	always_comb begin
		case (reg_idx)
			CFG_CHIP_ID:   prdata = {24'd0, chip_id_q};
			CFG_WIDE_DATA: prdata = {31'd0, wide_data_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign cfg.chip_id   = chip_id_q;
	assign cfg.wide_data = wide_data_q;

endmodule

// ----- src/asri_engine.sv -----
// Byte protocol engine and register set of the ADC serial register interface.
`timescale 1ns / 1ps
module asri_engine import asri_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_fire,
	input  in_item_t  in_item,
	output logic      res_valid,
	output out_item_t res_item
);

	logic [1:0]  bytes_left_q, bytes_left_d;
	logic [2:0]  reg_select_q, reg_select_d;
	logic        is_read_q, is_read_d;
	logic [23:0] shift_buf_q, shift_buf_d;
	logic [2:0]  ones_run_q, ones_run_d;
	logic [15:0] mode_word_q, mode_word_d;
	logic [15:0] config_word_q, config_word_d;
	logic [23:0] offset_word_q, offset_word_d;
	logic [23:0] fscale_word_q, fscale_word_d;
	logic [23:0] result_word_q, result_word_d;
	logic        ready_n_q, ready_n_d;

	logic [7:0]  b;
	logic [2:0]  sel;
	logic [1:0]  nbytes;
	logic [23:0] rd_value;
	logic [23:0] wr_buf;
	logic [7:0]  miso;

	assign b   = in_item.mosi_byte;
	assign sel = b[5:3];

	// Register size and value for the selected register
	always_comb begin
		case (sel)
			REG_MODE, REG_CONFIG:   nbytes = 2'd2;
			REG_DATA:               nbytes = cfg.wide_data ? 2'd3 : 2'd2;
			REG_OFFSET, REG_FSCALE: nbytes = 2'd3;
			default:                nbytes = 2'd1;
		endcase
		case (sel)
			REG_STATUS: rd_value = {16'd0, ready_n_q, 3'd0, cfg.wide_data, config_word_q[2:0]};
			REG_MODE:   rd_value = {8'd0, mode_word_q};
			REG_CONFIG: rd_value = {8'd0, config_word_q};
			REG_DATA:   rd_value = cfg.wide_data ? result_word_q : {8'd0, result_word_q[15:0]};
			REG_ID:     rd_value = {16'd0, cfg.chip_id};
			REG_OFFSET: rd_value = offset_word_q;
			REG_FSCALE: rd_value = fscale_word_q;
			default:    rd_value = 24'd0;
		endcase
	end

	assign wr_buf = {shift_buf_q[15:0], b};

	always_comb begin
		bytes_left_d  = bytes_left_q;
		reg_select_d  = reg_select_q;
		is_read_d     = is_read_q;
		shift_buf_d   = shift_buf_q;
		ones_run_d    = ones_run_q;
		mode_word_d   = mode_word_q;
		config_word_d = config_word_q;
		offset_word_d = offset_word_q;
		fscale_word_d = fscale_word_q;
		result_word_d = result_word_q;
		ready_n_d     = ready_n_q;
		miso          = IDLE_MISO;
		res_valid     = 1'b0;

		if (in_fire) begin
			case (in_item.cmd)
				CMD_CONV: begin
					result_word_d = in_item.sample;
					ready_n_d     = 1'b0;
				end
				CMD_DESEL: begin
					bytes_left_d = 2'd0;
					ones_run_d   = 3'd0;
				end
				CMD_XFER: begin
					res_valid = 1'b1;
					if (bytes_left_q == 2'd0) begin
						if (!b[7]) begin
							reg_select_d = sel;
							is_read_d    = b[6];
							if (sel == REG_STATUS && !b[6]) begin
								bytes_left_d = 2'd0;
							end else begin
								bytes_left_d = nbytes;
								if (!b[6]) begin
									shift_buf_d = 24'd0;
								end else begin
									// left-align so the MSB byte sits in the top lane
									case (nbytes)
										2'd1:    shift_buf_d = {rd_value[7:0], 16'd0};
										2'd2:    shift_buf_d = {rd_value[15:0], 8'd0};
										default: shift_buf_d = rd_value;
									endcase
								end
							end
						end
					end else if (is_read_q) begin
						miso         = shift_buf_q[23:16];
						shift_buf_d  = {shift_buf_q[15:0], 8'd0};
						bytes_left_d = bytes_left_q - 2'd1;
						if (bytes_left_q == 2'd1 && reg_select_q == REG_DATA)
							ready_n_d = 1'b1;
					end else begin
						shift_buf_d  = wr_buf;
						bytes_left_d = bytes_left_q - 2'd1;
						if (bytes_left_q == 2'd1) begin
							case (reg_select_q)
								REG_MODE:   mode_word_d   = wr_buf[15:0];
								REG_CONFIG: config_word_d = wr_buf[15:0];
								REG_OFFSET: offset_word_d = wr_buf;
								REG_FSCALE: fscale_word_d = wr_buf;
								default: ;
							endcase
						end
					end

					if (b == ONES_BYTE) begin
						ones_run_d = ones_run_q + 3'd1;
						if (ones_run_d >= ONES_RESET_RUN) begin
							bytes_left_d  = 2'd0;
							reg_select_d  = REG_STATUS;
							is_read_d     = 1'b0;
							shift_buf_d   = 24'd0;
							ones_run_d    = 3'd0;
							mode_word_d   = MODE_RST;
							config_word_d = CONFIG_RST;
							offset_word_d = OFFSET_RST;
							fscale_word_d = FSCALE_RST;
							result_word_d = 24'd0;
							ready_n_d     = 1'b1;
						end
					end else begin
						ones_run_d = 3'd0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= 2'd0;
			reg_select_q  <= REG_STATUS;
			is_read_q     <= 1'b0;
			shift_buf_q   <= 24'd0;
			ones_run_q    <= 3'd0;
			mode_word_q   <= MODE_RST;
			config_word_q <= CONFIG_RST;
			offset_word_q <= OFFSET_RST;
			fscale_word_q <= FSCALE_RST;
			result_word_q <= 24'd0;
			ready_n_q     <= 1'b1;
		end else begin
			bytes_left_q  <= bytes_left_d;
			reg_select_q  <= reg_select_d;
			is_read_q     <= is_read_d;
			shift_buf_q   <= shift_buf_d;
			ones_run_q    <= ones_run_d;
			mode_word_q   <= mode_word_d;
			config_word_q <= config_word_d;
			offset_word_q <= offset_word_d;
			fscale_word_q <= fscale_word_d;
			result_word_q <= result_word_d;
			ready_n_q     <= ready_n_d;
		end
	end

	assign res_item.miso_byte = miso;
	assign res_item.not_ready = ready_n_d;

endmodule

// ----- src/asri_out.sv -----
// Result register of the ADC serial register interface.
`timescale 1ns / 1ps
module asri_out import asri_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_valid,
	input  out_item_t res_item,
	output logic      take_ok,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic      valid_q;
	out_item_t data_q;

	// Free, or emptied in this same cycle
	assign take_ok = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_ok) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_ok && res_valid) begin
			data_q <= res_item;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ----- src/adc_serial_register_interface_top.sv -----
// Top level of the ADC serial register interface: slave side of the byte-wide register protocol.
`timescale 1ns / 1ps
// Each input transfer is one event: an SPI byte exchange, a conversion-complete
// notice carrying a new sample, or a chip deselect. Byte exchanges return one
// output transfer with the MISO byte (0xFF when no register is being shifted
// out) and the not-ready flag as it stands after the byte; the other events
// return nothing. Every event is decoded and applied to the register set in the
// cycle it is accepted, and its result lands in a single output register, so
// the block takes one transfer per clock; the only stall is a full output
// register that the sink is not draining. The output appears in the cycle after
// the input is accepted. Four 0xFF bytes in a row restore every register to its
// reset value; chip_id (APB 0x0) and wide_data (APB 0x4) are kept and should
// only be written while no transfer is in flight.
module adc_serial_register_interface_top import asri_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t      cfg;
	logic      in_fire;
	logic      res_valid;
	out_item_t res_item;

	asri_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_fire = in_valid && in_ready;

	asri_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_fire   (in_fire),
		.in_item   (in_data),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	asri_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_item  (res_item),
		.take_ok   (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
